/* hw/rtl/aad_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Annealing acceptance decision package
// Transaction types, fixed-point constants and the acceptance threshold table.
// ----------------------------------------------------------------------------
package aad_pkg;

  localparam int COST_WIDTH = 32;
  localparam int QW         = 32;
  localparam logic [QW-1:0] QMAX = '1;
  localparam logic [31:0] LN2_Q24 = 32'd11629080;

  typedef enum logic [1:0] {
    REG_START_PROB = 2'd0,
    REG_COOL_FACTOR = 2'd1,
    REG_ITER_PER_TEMP = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [COST_WIDTH-1:0] found_cost;
    logic [COST_WIDTH-1:0] current_cost;
    logic [3:0]            random_draw;
  } in_item_t;

  typedef struct packed {
    logic take_found;
    logic found_solves;
  } out_item_t;

  // ln(10/k) in Q8.24 for k = 1..9.
  function automatic logic [31:0] ln_ten_q24(input logic [3:0] k);
    logic [31:0] v;
    case (k)
      4'd1: v = 32'd38630967;
      4'd2: v = 32'd27001887;
      4'd3: v = 32'd20199312;
      4'd4: v = 32'd15372808;
      4'd5: v = 32'd11629080;
      4'd6: v = 32'd8570232;
      4'd7: v = 32'd5984013;
      4'd8: v = 32'd3743728;
      4'd9: v = 32'd1767656;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/aad_qdiv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring divider giving floor(num * 2^F / den), saturated to all ones.
// ----------------------------------------------------------------------------
module aad_qdiv #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [aad_pkg::QW-1:0] num,
  input  wire logic [aad_pkg::QW-1:0] den,
  output logic                      done,
  output logic [aad_pkg::QW-1:0]    quo
);
  import aad_pkg::*;

  localparam int NW = QW + FRACTION_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n;
  logic [QW-1:0] r;
  logic [QW-1:0] q;
  logic [QW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [QW:0]   trial;
  logic [QW:0]   sub;
  logic          ge;
  logic          sat;

  assign trial = {r, n[NW-1]};
  assign sub   = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  // The quotient overflows when num >= den * 2^(32-F).
  assign sat   = {32'd0, num} >= ({32'd0, den} << (QW - FRACTION_BITS));
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          q    <= QMAX;
          done <= 1'b1;
        end else begin
          n     <= {num, {FRACTION_BITS{1'b0}}};
          r     <= '0;
          q     <= '0;
          den_r <= den;
          cnt   <= '0;
          busy  <= 1'b1;
        end
      end else if (busy) begin
        r   <= ge ? sub[QW-1:0] : trial[QW-1:0];
        q   <= {q[QW-2:0], ge};
        n   <= {n[NW-2:0], 1'b0};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/annealing_acceptance_decision.sv */
`default_nettype none
// Flow: a zero found cost goes straight to S_DONE with no division. Each division holds
// the shared divider until it is done, and a quotient that saturates skips the shift loop;
// a normal item needs two divisions (cost difference, then difference over temperature), and a
// cooling step adds S_COOL. The first item adds a third division for the start temperature,
// with the normalize, log squaring and ln steps before it.
// One item at a time. Reset restores register defaults and clears the annealing state.
// ----------------------------------------------------------------------------
// Annealing acceptance decision
// Simulated annealing accept/reject with geometric cooling in unsigned fixed point.
// ----------------------------------------------------------------------------
module annealing_acceptance_decision #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire aad_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output aad_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import aad_pkg::*;

  localparam logic [QW-1:0] EPS = QW'(((2 ** FRACTION_BITS) * 2 + 50) / 100);
  localparam int TSH = 24 - FRACTION_BITS;
  localparam int NSH = 56 - FRACTION_BITS;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_DIFF   = 15'b000000000000010,
    S_NORM   = 15'b000000000000100,
    S_SQ_MUL = 15'b000000000001000,
    S_SQ_UPD = 15'b000000000010000,
    S_LN_LO  = 15'b000000000100000,
    S_LN_HI  = 15'b000000001000000,
    S_LN_FIN = 15'b000000010000000,
    S_TDIV   = 15'b000000100000000,
    S_COUNT  = 15'b000001000000000,
    S_COOL   = 15'b000010000000000,
    S_XSTART = 15'b000100000000000,
    S_XDIV   = 15'b001000000000000,
    S_DECIDE = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

  state_t state;

  logic [15:0]   start_prob;
  logic [15:0]   cooling_factor;
  logic [15:0]   iterations_per_temperature;
  logic          has_started;
  logic [QW-1:0] temperature;
  logic [16:0]   steps_at_temperature;

  logic [3:0]    draw;
  logic [QW-1:0] diff;
  logic [QW-1:0] x;
  logic [15:0]   pn;
  logic [3:0]    shift_cnt;
  logic [31:0]   m;
  logic [31:0]   frac;
  logic [4:0]    sq_cnt;
  logic [63:0]   prod;
  logic [63:0]   acc;
  logic          res_take;
  logic          res_solves;

  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [36:0]   nl2;
  logic [63:0]   nl_sum;
  logic [QW-1:0] nl;
  logic [32:0]   sq;
  logic [16:0]   steps_inc;
  logic [QW-1:0] thr;
  logic [QW-1:0] abs_diff;

  logic          div_start;
  logic [QW-1:0] div_num;
  logic [QW-1:0] div_den;
  logic          div_done;
  logic [QW-1:0] div_quo;

  aad_qdiv #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ready  = (state == S_IDLE);
  assign abs_diff  = (in_data.found_cost > in_data.current_cost) ?
                     in_data.found_cost - in_data.current_cost :
                     in_data.current_cost - in_data.found_cost;
  // -log2(p) = (s + 1) - fractional log2 of the normalized mantissa.
  assign nl2       = {5'({1'b0, shift_cnt} + 5'd1), 32'd0} - {5'd0, frac};
  assign nl_sum    = {prod[31:0], 32'd0} + acc;
  assign nl        = (nl_sum >> NSH) == 64'd0 ? QW'(1) : QW'(nl_sum >> NSH);
  assign sq        = prod[63:31];
  assign steps_inc = steps_at_temperature + 17'd1;
  assign thr       = QW'(ln_ten_q24(draw) >> TSH);

  always_comb begin
    case (state)
      S_SQ_MUL: begin
        mul_a = m;
        mul_b = m;
      end
      S_LN_LO: begin
        mul_a = nl2[31:0];
        mul_b = LN2_Q24;
      end
      S_LN_HI: begin
        mul_a = {27'd0, nl2[36:32]};
        mul_b = LN2_Q24;
      end
      default: begin
        mul_a = temperature;
        mul_b = {16'd0, cooling_factor};
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = diff;
    div_den   = temperature;
    case (state)
      S_IDLE: begin
        div_start = in_valid && (in_data.found_cost != '0);
        div_num   = abs_diff;
        div_den   = in_data.found_cost;
      end
      S_LN_FIN: begin
        div_start = 1'b1;
        div_den   = nl;
      end
      S_XSTART: begin
        div_start = (temperature != '0);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_prob                 <= 16'd32768;
      cooling_factor             <= 16'd62259;
      iterations_per_temperature <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_PROB:    start_prob                 <= cfg_data;
        REG_COOL_FACTOR:   cooling_factor             <= cfg_data;
        REG_ITER_PER_TEMP: iterations_per_temperature <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      has_started          <= 1'b0;
      temperature          <= '0;
      steps_at_temperature <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            draw <= in_data.random_draw;
            if (in_data.found_cost == '0) begin
              res_take   <= 1'b1;
              res_solves <= 1'b1;
              state      <= S_DONE;
            end else begin
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          if (div_done) begin
            diff <= (div_quo < EPS) ? EPS : div_quo;
            if (has_started) begin
              state <= S_COUNT;
            end else begin
              pn        <= (start_prob == 16'd0) ? 16'd1 : start_prob;
              shift_cnt <= '0;
              state     <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (pn[15]) begin
            m      <= {pn, 16'd0};
            frac   <= '0;
            sq_cnt <= '0;
            state  <= S_SQ_MUL;
          end else begin
            pn        <= {pn[14:0], 1'b0};
            shift_cnt <= shift_cnt + 4'd1;
          end
        end
        S_SQ_MUL: begin
          state <= S_SQ_UPD;
        end
        S_SQ_UPD: begin
          // Each squaring yields one fraction bit of log2 of the mantissa.
          if (sq[32]) begin
            m    <= sq[32:1];
            frac <= {frac[30:0], 1'b1};
          end else begin
            m    <= sq[31:0];
            frac <= {frac[30:0], 1'b0};
          end
          sq_cnt <= sq_cnt + 5'd1;
          state  <= (sq_cnt == 5'd31) ? S_LN_LO : S_SQ_MUL;
        end
        S_LN_LO: begin
          state <= S_LN_HI;
        end
        S_LN_HI: begin
          acc   <= prod;
          state <= S_LN_FIN;
        end
        S_LN_FIN: begin
          state <= S_TDIV;
        end
        S_TDIV: begin
          if (div_done) begin
            temperature <= div_quo;
            has_started <= 1'b1;
            state       <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (steps_inc > {1'b0, iterations_per_temperature}) begin
            steps_at_temperature <= '0;
            state                <= S_COOL;
          end else begin
            steps_at_temperature <= steps_inc;
            state                <= S_XSTART;
          end
        end
        S_COOL: begin
          temperature <= prod[47:16];
          state       <= S_XSTART;
        end
        S_XSTART: begin
          if (temperature == '0) begin
            x     <= QMAX;
            state <= S_DECIDE;
          end else begin
            state <= S_XDIV;
          end
        end
        S_XDIV: begin
          if (div_done) begin
            x     <= div_quo;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_solves <= 1'b0;
          if (draw >= 4'd10) begin
            res_take <= 1'b1;
          end else if (draw == 4'd0) begin
            res_take <= (x == QMAX);
          end else begin
            res_take <= (x >= thr);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.take_found   <= res_take;
            out_data.found_solves <= res_solves;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
